FILE: sv/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg: shared types, constants and tables for the heightmap slope block
// Field widths, CORDIC datapath types, arctangent table and angle rounding.
// ----------------------------------------------------------------------------
package hms_pkg;

  // Grid geometry: coordinates cover the full grid.
  localparam int COORD_W   = 6;
  localparam int GRID_SIZE = 1 << COORD_W;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int MEM_DEPTH = GRID_SIZE * GRID_SIZE;

  // Heights: signed Q15.4.
  localparam int HEIGHT_W = 20;
  localparam int DIFF_W   = HEIGHT_W + 1;

  // CORDIC datapath.
  localparam int XY_W         = 50;
  localparam int Z_W          = 29;
  localparam int CORDIC_STEPS = 24;
  localparam int ITER_W       = 5;
  localparam int DIFF_SHIFT   = 26;
  localparam int ANGLE_FRAC   = 12;
  localparam int SLOPE_W      = 15;
  localparam int SLOPE_MAX    = 23040;

  localparam logic signed [XY_W-1:0] RUN_ORTHO = XY_W'(64'd1073741824);
  localparam logic signed [XY_W-1:0] RUN_DIAG  = XY_W'(64'd1518500250);

  // Read sequence: center plus eight neighbors.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] NBR_COUNT = STEP_W'(9);

  // Action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic        [DIFF_W-1:0]   diff_t;
  typedef logic signed [XY_W-1:0]     xy_t;
  typedef logic signed [Z_W-1:0]      z_t;
  typedef logic        [ITER_W-1:0]   iter_t;
  typedef logic        [SLOPE_W-1:0]  slope_t;
  typedef logic signed [1:0]          offs_t;

  typedef struct packed {
    xy_t x;
    xy_t y;
    z_t  z;
  } cordic_t;

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  function automatic z_t atan_entry(input iter_t i);
    z_t v;
    case (i)
      5'd0:    v = Z_W'(47185920);
      5'd1:    v = Z_W'(27855475);
      5'd2:    v = Z_W'(14718068);
      5'd3:    v = Z_W'(7471121);
      5'd4:    v = Z_W'(3750058);
      5'd5:    v = Z_W'(1876857);
      5'd6:    v = Z_W'(938658);
      5'd7:    v = Z_W'(469357);
      5'd8:    v = Z_W'(234682);
      5'd9:    v = Z_W'(117342);
      5'd10:   v = Z_W'(58671);
      5'd11:   v = Z_W'(29335);
      5'd12:   v = Z_W'(14668);
      5'd13:   v = Z_W'(7334);
      5'd14:   v = Z_W'(3667);
      5'd15:   v = Z_W'(1833);
      5'd16:   v = Z_W'(917);
      5'd17:   v = Z_W'(458);
      5'd18:   v = Z_W'(229);
      5'd19:   v = Z_W'(115);
      5'd20:   v = Z_W'(57);
      5'd21:   v = Z_W'(29);
      5'd22:   v = Z_W'(14);
      5'd23:   v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Neighbor order: center first, then row by row.
  function automatic offs_t nbr_dr(input logic [STEP_W-1:0] k);
    offs_t v;
    case (k)
      4'd1, 4'd2, 4'd3: v = -2'sd1;
      4'd6, 4'd7, 4'd8: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic offs_t nbr_dc(input logic [STEP_W-1:0] k);
    offs_t v;
    case (k)
      4'd1, 4'd4, 4'd6: v = -2'sd1;
      4'd3, 4'd5, 4'd8: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  // 2^-20 degree accumulator to 1/256 degree, half up, limited to 0..SLOPE_MAX.
  function automatic slope_t angle_round(input z_t z);
    logic signed [Z_W:0] sum;
    slope_t v;
    sum = $signed({z[Z_W-1], z}) + $signed((Z_W+1)'(1 << (ANGLE_FRAC - 1)));
    sum = sum >>> ANGLE_FRAC;
    if (z[Z_W-1]) begin
      v = '0;
    end else if (sum > $signed((Z_W+1)'(SLOPE_MAX))) begin
      v = SLOPE_W'(SLOPE_MAX);
    end else begin
      v = sum[SLOPE_W-1:0];
    end
    return v;
  endfunction

endpackage

FILE: sv/hms_height_ram.sv
// ----------------------------------------------------------------------------
// hms_height_ram: heightmap storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hms_height_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [hms_pkg::ADDR_W-1:0] wr_addr,
  input  hms_pkg::height_t        wr_data,
  input  logic [hms_pkg::ADDR_W-1:0] rd_addr,
  output hms_pkg::height_t        rd_data
);
  import hms_pkg::*;

  height_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/hms_cordic_step.sv
// ----------------------------------------------------------------------------
// hms_cordic_step: one CORDIC vectoring iteration
// Rotates (x, y) toward the x axis by atan(2^-i), shifts truncate toward zero.
// ----------------------------------------------------------------------------
module hms_cordic_step (
  input  hms_pkg::cordic_t cur,
  input  hms_pkg::iter_t   iter,
  output hms_pkg::cordic_t nxt
);
  import hms_pkg::*;

  // Arithmetic shift with the result rounded toward zero.
  function automatic xy_t shr_tz(input xy_t v, input iter_t s);
    logic [XY_W-1:0] mask;
    xy_t             sh;
    logic            corr;
    mask = ~({XY_W{1'b1}} << s);
    sh   = v >>> s;
    corr = v[XY_W-1] & (|(v & mask));
    return sh + $signed({{(XY_W-1){1'b0}}, corr});
  endfunction

  xy_t  dx;
  xy_t  dy;
  z_t   da;
  logic y_pos;

  assign dx    = shr_tz(cur.y, iter);
  assign dy    = shr_tz(cur.x, iter);
  assign da    = atan_entry(iter);
  assign y_pos = !cur.y[XY_W-1];

  always_comb begin
    if (y_pos) begin
      nxt.x = cur.x + dx;
      nxt.y = cur.y - dy;
      nxt.z = cur.z + da;
    end else begin
      nxt.x = cur.x - dx;
      nxt.y = cur.y + dy;
      nxt.z = cur.z - da;
    end
  end

endmodule

FILE: sv/heightmap_max_neighbor_slope.sv
// ----------------------------------------------------------------------------
// heightmap_max_neighbor_slope: steepest D8 slope around a heightmap cell
// Stores a 64 x 64 map of Q15.4 heights and answers slope queries using one
// shared CORDIC iteration unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in_     | input     | in_valid / in_stall  | action, col, row, height_in
//  out_    | output    | out_valid / out_stall| slope_deg (1/256 degree)
//
//  A write transaction is stored on its accept edge; the block is ready again
//  in the next cycle and gives no result.
//  A query reads the center and its 8 neighbors through the single read port,
//  then runs two passes of a load, 24 CORDIC iterations and a round through
//  the one shared step unit, and then moves the result into the output
//  register once that register is free.
//  in_stall stays high from the query's accept until its result moves into the
//  output register; a result waiting there does not hold the input side, but a
//  later query's result waits in the sequencer until the register frees up.
//  Reset (rst_n, synchronous) clears the sequencer and the output valid only;
//  the height store is not cleared and a cell must be written before it is read.
// ----------------------------------------------------------------------------
module heightmap_max_neighbor_slope (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [hms_pkg::COORD_W-1:0] in_col,
  input  logic [hms_pkg::COORD_W-1:0] in_row,
  input  hms_pkg::height_t            in_height_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output hms_pkg::slope_t             out_slope_deg
);
  import hms_pkg::*;

  // Sequencer states.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;  // ready for a transaction
  localparam logic [ST_W-1:0] ST_READ = 3'd1;  // sweep center and neighbors
  localparam logic [ST_W-1:0] ST_LOAD = 3'd2;  // seed CORDIC for one run
  localparam logic [ST_W-1:0] ST_ITER = 3'd3;  // CORDIC iterations
  localparam logic [ST_W-1:0] ST_FIN  = 3'd4;  // round angle, keep the max
  localparam logic [ST_W-1:0] ST_OUT  = 3'd5;  // result waits for the output reg

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  iter_t             iter_r, iter_nxt;
  logic              pass_r, pass_nxt;   // 0: orthogonal run, 1: diagonal run
  logic              prev_vld_r;         // read data of last cycle is live

  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [STEP_W-1:0]  prev_idx_r;
  logic               prev_in_r;
  height_t            center_r;
  diff_t              max_ortho_r;
  diff_t              max_diag_r;
  cordic_t            cor_r;
  slope_t             best_r;

  // Output register: frees the sequencer while a result waits.
  logic               out_valid_r;
  slope_t             out_slope_r;
  logic               out_load;

  logic in_accept;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Neighbor address for the current read step. Coordinates are widened by
  // two bits so that -1 and GRID_SIZE fall outside the valid range.
  // --------------------------------------------------------------------------
  logic signed [COORD_W+1:0] nbr_r_s;
  logic signed [COORD_W+1:0] nbr_c_s;
  logic                      nbr_inside;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      wr_en;
  height_t                   rd_data;

  assign nbr_r_s = $signed({2'b00, row_r}) + (COORD_W+2)'(nbr_dr(step_r));
  assign nbr_c_s = $signed({2'b00, col_r}) + (COORD_W+2)'(nbr_dc(step_r));
  assign nbr_inside = (nbr_r_s >= 0) && (nbr_r_s < $signed((COORD_W+2)'(GRID_SIZE)))
                   && (nbr_c_s >= 0) && (nbr_c_s < $signed((COORD_W+2)'(GRID_SIZE)));
  assign rd_addr = {nbr_r_s[COORD_W-1:0], nbr_c_s[COORD_W-1:0]};
  assign wr_addr = {in_row, in_col};
  assign wr_en   = in_accept && (in_action == ACT_WRITE);

  hms_height_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_height_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Absolute height difference against the center for returning read data.
  logic signed [DIFF_W-1:0] diff_s;
  diff_t                    diff_abs;
  logic                     prev_diag;

  assign diff_s    = $signed({rd_data[HEIGHT_W-1], rd_data})
                   - $signed({center_r[HEIGHT_W-1], center_r});
  assign diff_abs  = diff_s[DIFF_W-1] ? diff_t'(-diff_s) : diff_t'(diff_s);
  assign prev_diag = (nbr_dr(prev_idx_r) != 2'sd0) && (nbr_dc(prev_idx_r) != 2'sd0);

  // --------------------------------------------------------------------------
  // Shared CORDIC iteration unit.
  // --------------------------------------------------------------------------
  cordic_t cor_step;

  hms_cordic_step u_step (
    .cur  (cor_r),
    .iter (iter_r),
    .nxt  (cor_step)
  );

  diff_t  diff_sel;
  slope_t angle;

  assign diff_sel = pass_r ? max_diag_r : max_ortho_r;
  // A zero difference means a flat run: angle 0 without looking at z.
  assign angle    = (diff_sel == '0) ? '0 : angle_round(cor_r.z);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    pass_nxt  = pass_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_action == ACT_QUERY)) begin
          state_nxt = ST_READ;
          step_nxt  = '0;
          pass_nxt  = 1'b0;
        end
      end
      ST_READ: begin
        step_nxt = step_r + 1'b1;
        // last step only drains the read data of the final neighbor
        if (step_r == NBR_COUNT) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        iter_nxt  = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      iter_r      <= '0;
      pass_r      <= 1'b0;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      iter_r     <= iter_nxt;
      pass_r     <= pass_nxt;
      prev_vld_r <= (state_r == ST_READ) && (step_r < NBR_COUNT);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers (no reset needed)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prev_idx_r <= step_r;
    prev_in_r  <= nbr_inside;

    if (in_accept) begin
      row_r       <= in_row;
      col_r       <= in_col;
      max_ortho_r <= '0;
      max_diag_r  <= '0;
    end

    // Read data arrives in the cycle after its address; index 0 is the center.
    if (prev_vld_r) begin
      if (prev_idx_r == '0) begin
        center_r <= rd_data;
      end else if (prev_in_r) begin
        if (prev_diag) begin
          if (diff_abs > max_diag_r) begin
            max_diag_r <= diff_abs;
          end
        end else begin
          if (diff_abs > max_ortho_r) begin
            max_ortho_r <= diff_abs;
          end
        end
      end
    end

    if (out_load) begin
      out_slope_r <= best_r;
    end

    case (state_r)
      ST_LOAD: begin
        cor_r.x <= pass_r ? RUN_DIAG : RUN_ORTHO;
        cor_r.y <= $signed(XY_W'({diff_sel, {DIFF_SHIFT{1'b0}}}));
        cor_r.z <= '0;
      end
      ST_ITER: begin
        cor_r <= cor_step;
      end
      ST_FIN: begin
        if (!pass_r) begin
          best_r <= angle;
        end else if (angle > best_r) begin
          best_r <= angle;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_slope_deg = out_slope_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_action == ACT_WRITE) |=> (state_r == ST_IDLE))
    else $error("write transaction left the idle state");

  a_query_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_action == ACT_QUERY) |=> (state_r == ST_READ) && (step_r == '0))
    else $error("query did not start the read sweep");

  a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slope_deg <= SLOPE_W'(SLOPE_MAX)))
    else $error("slope result out of range");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER) |-> (iter_r < ITER_W'(CORDIC_STEPS)))
    else $error("CORDIC iteration count overran");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slope_deg))
    else $error("result changed while stalled");

endmodule
